### rtl/gga_sentence_field_extractor_unit_defines.svh
// assertion macros for the gga sentence field extractor
`ifndef GGA_SENTENCE_FIELD_EXTRACTOR_UNIT_DEFINES_SVH
`define GGA_SENTENCE_FIELD_EXTRACTOR_UNIT_DEFINES_SVH

// same-cycle implication, off during reset
`define GGA_SFX_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, off during reset
`define GGA_SFX_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

// next-cycle implication that also watches reset itself
`define GGA_SFX_ASSERT_RST(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) (ante) |=> (cons)) \
    else $error(msg);

`endif

### rtl/gga_sfx_pkg.sv
// types, constants and helpers shared by the gga sentence field extractor
package gga_sfx_pkg;

  localparam logic [5:0] SENTENCE_SEGMENTS  = 6'd15;
  localparam logic [3:0] MINUTE_FRAC_DIGITS = 4'd7;
  localparam logic [3:0] METRE_FRAC_DIGITS  = 4'd4;
  localparam logic [3:0] HDOP_FRAC_DIGITS   = 4'd2;
  localparam logic [3:0] NO_FRAC_DIGITS     = 4'd0;

  localparam logic [31:0] CAP_TWO_DIGIT   = 32'd99;
  localparam logic [31:0] CAP_THREE_DIGIT = 32'd999;
  localparam logic [31:0] CAP_ONE_DIGIT   = 32'd9;
  localparam logic [31:0] CAP_SATS        = 32'd255;
  localparam logic [31:0] CAP_HDOP        = 32'd65535;
  localparam logic [31:0] CAP_MINUTES     = 32'd999999999;
  localparam logic [31:0] CAP_MAGNITUDE   = 32'h8000_0000;
  localparam logic [31:0] MAX_POSITIVE    = 32'h7FFF_FFFF;

  localparam logic [7:0] CHAR_COMMA = 8'h2C;
  localparam logic [7:0] CHAR_POINT = 8'h2E;
  localparam logic [7:0] CHAR_MINUS = 8'h2D;
  localparam logic [7:0] CHAR_PLUS  = 8'h2B;
  localparam logic [7:0] CHAR_ZERO  = 8'h30;
  localparam logic [7:0] CHAR_NINE  = 8'h39;
  localparam logic [7:0] CHAR_N     = 8'h4E;
  localparam logic [7:0] CHAR_E     = 8'h45;

  localparam logic [4:0] SEG_TIME    = 5'd1;
  localparam logic [4:0] SEG_LAT     = 5'd2;
  localparam logic [4:0] SEG_NS      = 5'd3;
  localparam logic [4:0] SEG_LON     = 5'd4;
  localparam logic [4:0] SEG_EW      = 5'd5;
  localparam logic [4:0] SEG_QUALITY = 5'd6;
  localparam logic [4:0] SEG_SATS    = 5'd7;
  localparam logic [4:0] SEG_HDOP    = 5'd8;
  localparam logic [4:0] SEG_ALT     = 5'd9;
  localparam logic [4:0] SEG_UND     = 5'd11;
  localparam logic [4:0] SEG_MAX     = 5'd31;
  localparam logic [5:0] POS_MAX     = 6'd63;

  typedef struct packed {
    logic [7:0] sentence_byte;
    logic       last_byte;
  } in_beat_t;

  typedef struct packed {
    logic               status;
    logic [20:0]        utc_time_packed;
    logic [6:0]         lat_degrees;
    logic [29:0]        lat_minutes_e7;
    logic [9:0]         lon_degrees;
    logic [29:0]        lon_minutes_e7;
    logic [1:0]         hemisphere_flags;
    logic [3:0]         fix_quality;
    logic [7:0]         sats_in_use;
    logic [15:0]        hdop_e2;
    logic signed [31:0] altitude_e4;
    logic signed [31:0] undulation_e4;
  } out_beat_t;

  typedef struct packed {
    logic       stopped;
    logic       after_point;
    logic [3:0] frac_seen;
  } scan_ctl_t;

  typedef enum logic [3:0] {
    SEL_NONE,
    SEL_HOURS,
    SEL_MINUTES,
    SEL_SECONDS,
    SEL_LAT_DEG,
    SEL_LAT_MIN,
    SEL_LON_DEG,
    SEL_LON_MIN,
    SEL_QUALITY,
    SEL_SATS,
    SEL_HDOP,
    SEL_ALT,
    SEL_UND
  } acc_sel_t;

  function automatic logic [29:0] pow10(input logic [3:0] n);
    logic [29:0] v;
    unique case (n)
      4'd0:    v = 30'd1;
      4'd1:    v = 30'd10;
      4'd2:    v = 30'd100;
      4'd3:    v = 30'd1000;
      4'd4:    v = 30'd10000;
      4'd5:    v = 30'd100000;
      4'd6:    v = 30'd1000000;
      4'd7:    v = 30'd10000000;
      4'd8:    v = 30'd100000000;
      default: v = 30'd1000000000;
    endcase
    return v;
  endfunction

endpackage

### rtl/gga_sfx_scan.sv
// one digit step of a fixed-point decimal accumulator with saturation
module gga_sfx_scan (
  input  logic [31:0]             acc_i,
  input  logic [7:0]              ch_i,
  input  logic [3:0]              frac_i,
  input  logic [31:0]             cap_i,
  input  gga_sfx_pkg::scan_ctl_t  ctl_i,
  output logic [31:0]             acc_o,
  output gga_sfx_pkg::scan_ctl_t  ctl_o
);
  import gga_sfx_pkg::*;

  logic        digit;
  logic [3:0]  dval;
  logic [3:0]  seen_inc;
  logic [3:0]  weight;
  logic [33:0] scaled;
  logic [35:0] acc_wide;
  logic [35:0] sum;
  logic [31:0] sat;

  assign digit    = (ch_i >= CHAR_ZERO) && (ch_i <= CHAR_NINE);
  assign dval     = ch_i[3:0];
  assign seen_inc = ctl_i.frac_seen + 4'd1;
  assign weight   = ctl_i.after_point ? (frac_i - seen_inc) : frac_i;
  assign scaled   = {30'd0, dval} * {4'd0, pow10(weight)};
  assign acc_wide = {4'd0, acc_i};

  always_comb begin
    if (ctl_i.after_point) begin
      sum = acc_wide + {2'd0, scaled};
    end else begin
      sum = (acc_wide << 3) + (acc_wide << 1) + {2'd0, scaled};
    end
    sat = (sum > {4'd0, cap_i}) ? cap_i : sum[31:0];
  end

  always_comb begin
    acc_o = acc_i;
    ctl_o = ctl_i;
    if (!ctl_i.stopped) begin
      priority if (digit) begin
        if (!ctl_i.after_point) begin
          acc_o = sat;
        end else if (ctl_i.frac_seen < frac_i) begin
          ctl_o.frac_seen = seen_inc;
          acc_o           = sat;
        end
      end else if (ch_i == CHAR_POINT && frac_i != NO_FRAC_DIGITS && !ctl_i.after_point) begin
        ctl_o.after_point = 1'b1;
      end else begin
        ctl_o.stopped = 1'b1;
      end
    end
  end

endmodule

### rtl/gga_sfx_parser.sv
// sentence state, per-byte field routing and record assembly
module gga_sfx_parser (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   step_i,
  input  gga_sfx_pkg::in_beat_t  beat_i,
  output logic                   rec_valid_o,
  output gga_sfx_pkg::out_beat_t rec_o
);
  import gga_sfx_pkg::*;

  logic [4:0]  seg_r, seg_upd, seg_nxt;
  logic [5:0]  pos_r, pos_upd, pos_nxt;
  scan_ctl_t   ctl_r, ctl_upd, ctl_nxt;
  logic [6:0]  hours_r, hours_upd, hours_nxt;
  logic [6:0]  mins_r, mins_upd, mins_nxt;
  logic [6:0]  secs_r, secs_upd, secs_nxt;
  logic [6:0]  lat_deg_r, lat_deg_upd, lat_deg_nxt;
  logic [29:0] lat_min_r, lat_min_upd, lat_min_nxt;
  logic [9:0]  lon_deg_r, lon_deg_upd, lon_deg_nxt;
  logic [29:0] lon_min_r, lon_min_upd, lon_min_nxt;
  logic [3:0]  quality_r, quality_upd, quality_nxt;
  logic [7:0]  sats_r, sats_upd, sats_nxt;
  logic [15:0] hdop_r, hdop_upd, hdop_nxt;
  logic [31:0] alt_r, alt_upd, alt_nxt;
  logic [31:0] und_r, und_upd, und_nxt;
  logic        flag_lat_r, flag_lat_upd, flag_lat_nxt;
  logic        flag_lon_r, flag_lon_upd, flag_lon_nxt;
  logic        alt_neg_r, alt_neg_upd, alt_neg_nxt;
  logic        und_neg_r, und_neg_upd, und_neg_nxt;

  acc_sel_t    sel;
  logic        clr;
  logic [7:0]  ch;
  logic [31:0] scan_acc_in;
  logic [3:0]  scan_frac;
  logic [31:0] scan_cap;
  scan_ctl_t   scan_ctl_in;
  logic [31:0] scan_acc_out;
  scan_ctl_t   scan_ctl_out;
  logic        last;

  assign ch   = beat_i.sentence_byte;
  assign last = step_i && beat_i.last_byte;

  // which accumulator this character feeds
  always_comb begin
    sel = SEL_NONE;
    clr = 1'b0;
    if (ch != CHAR_COMMA) begin
      unique case (seg_r)
        SEG_TIME: begin
          clr = (pos_r == 6'd2) || (pos_r == 6'd4);
          if (pos_r < 6'd2) begin
            sel = SEL_HOURS;
          end else if (pos_r < 6'd4) begin
            sel = SEL_MINUTES;
          end else if (pos_r < 6'd6) begin
            sel = SEL_SECONDS;
          end
        end
        SEG_LAT: begin
          clr = (pos_r == 6'd2);
          sel = (pos_r < 6'd2) ? SEL_LAT_DEG : SEL_LAT_MIN;
        end
        SEG_LON: begin
          clr = (pos_r == 6'd3);
          sel = (pos_r < 6'd3) ? SEL_LON_DEG : SEL_LON_MIN;
        end
        SEG_QUALITY: begin
          if (pos_r == 6'd0) begin
            sel = SEL_QUALITY;
          end
        end
        SEG_SATS: sel = SEL_SATS;
        SEG_HDOP: sel = SEL_HDOP;
        SEG_ALT: begin
          if (!(pos_r == 6'd0 && (ch == CHAR_MINUS || ch == CHAR_PLUS))) begin
            sel = SEL_ALT;
          end
        end
        SEG_UND: begin
          if (!(pos_r == 6'd0 && (ch == CHAR_MINUS || ch == CHAR_PLUS))) begin
            sel = SEL_UND;
          end
        end
        default: sel = SEL_NONE;
      endcase
    end
  end

  always_comb begin
    scan_acc_in = 32'd0;
    scan_frac   = NO_FRAC_DIGITS;
    scan_cap    = CAP_TWO_DIGIT;
    unique case (sel)
      SEL_HOURS:   scan_acc_in = {25'd0, hours_r};
      SEL_MINUTES: scan_acc_in = {25'd0, mins_r};
      SEL_SECONDS: scan_acc_in = {25'd0, secs_r};
      SEL_LAT_DEG: scan_acc_in = {25'd0, lat_deg_r};
      SEL_LAT_MIN: begin
        scan_acc_in = {2'd0, lat_min_r};
        scan_frac   = MINUTE_FRAC_DIGITS;
        scan_cap    = CAP_MINUTES;
      end
      SEL_LON_DEG: begin
        scan_acc_in = {22'd0, lon_deg_r};
        scan_cap    = CAP_THREE_DIGIT;
      end
      SEL_LON_MIN: begin
        scan_acc_in = {2'd0, lon_min_r};
        scan_frac   = MINUTE_FRAC_DIGITS;
        scan_cap    = CAP_MINUTES;
      end
      SEL_QUALITY: begin
        scan_acc_in = {28'd0, quality_r};
        scan_cap    = CAP_ONE_DIGIT;
      end
      SEL_SATS: begin
        scan_acc_in = {24'd0, sats_r};
        scan_cap    = CAP_SATS;
      end
      SEL_HDOP: begin
        scan_acc_in = {16'd0, hdop_r};
        scan_frac   = HDOP_FRAC_DIGITS;
        scan_cap    = CAP_HDOP;
      end
      SEL_ALT: begin
        scan_acc_in = alt_r;
        scan_frac   = METRE_FRAC_DIGITS;
        scan_cap    = CAP_MAGNITUDE;
      end
      SEL_UND: begin
        scan_acc_in = und_r;
        scan_frac   = METRE_FRAC_DIGITS;
        scan_cap    = CAP_MAGNITUDE;
      end
      default: scan_acc_in = 32'd0;
    endcase
  end

  assign scan_ctl_in = clr ? '0 : ctl_r;

  gga_sfx_scan u_scan (
    .acc_i (scan_acc_in),
    .ch_i  (ch),
    .frac_i(scan_frac),
    .cap_i (scan_cap),
    .ctl_i (scan_ctl_in),
    .acc_o (scan_acc_out),
    .ctl_o (scan_ctl_out)
  );

  // state after this byte, before the end-of-sentence clear
  always_comb begin
    seg_upd      = seg_r;
    pos_upd      = pos_r;
    ctl_upd      = ctl_r;
    hours_upd    = hours_r;
    mins_upd     = mins_r;
    secs_upd     = secs_r;
    lat_deg_upd  = lat_deg_r;
    lat_min_upd  = lat_min_r;
    lon_deg_upd  = lon_deg_r;
    lon_min_upd  = lon_min_r;
    quality_upd  = quality_r;
    sats_upd     = sats_r;
    hdop_upd     = hdop_r;
    alt_upd      = alt_r;
    und_upd      = und_r;
    flag_lat_upd = flag_lat_r;
    flag_lon_upd = flag_lon_r;
    alt_neg_upd  = alt_neg_r;
    und_neg_upd  = und_neg_r;
    if (ch == CHAR_COMMA) begin
      seg_upd = (seg_r == SEG_MAX) ? seg_r : seg_r + 5'd1;
      pos_upd = 6'd0;
      ctl_upd = '0;
      if (seg_upd == SEG_NS) begin
        flag_lat_upd = 1'b1;
      end
      if (seg_upd == SEG_EW) begin
        flag_lon_upd = 1'b1;
      end
    end else begin
      pos_upd = (pos_r == POS_MAX) ? pos_r : pos_r + 6'd1;
      ctl_upd = (sel == SEL_NONE) ? scan_ctl_in : scan_ctl_out;
      if (seg_r == SEG_NS && pos_r == 6'd0 && ch == CHAR_N) begin
        flag_lat_upd = 1'b0;
      end
      if (seg_r == SEG_EW && pos_r == 6'd0 && ch == CHAR_E) begin
        flag_lon_upd = 1'b0;
      end
      if (seg_r == SEG_ALT && pos_r == 6'd0 && ch == CHAR_MINUS) begin
        alt_neg_upd = 1'b1;
      end
      if (seg_r == SEG_UND && pos_r == 6'd0 && ch == CHAR_MINUS) begin
        und_neg_upd = 1'b1;
      end
      unique case (sel)
        SEL_HOURS:   hours_upd   = scan_acc_out[6:0];
        SEL_MINUTES: mins_upd    = scan_acc_out[6:0];
        SEL_SECONDS: secs_upd    = scan_acc_out[6:0];
        SEL_LAT_DEG: lat_deg_upd = scan_acc_out[6:0];
        SEL_LAT_MIN: lat_min_upd = scan_acc_out[29:0];
        SEL_LON_DEG: lon_deg_upd = scan_acc_out[9:0];
        SEL_LON_MIN: lon_min_upd = scan_acc_out[29:0];
        SEL_QUALITY: quality_upd = scan_acc_out[3:0];
        SEL_SATS:    sats_upd    = scan_acc_out[7:0];
        SEL_HDOP:    hdop_upd    = scan_acc_out[15:0];
        SEL_ALT:     alt_upd     = scan_acc_out;
        SEL_UND:     und_upd     = scan_acc_out;
        default:     hours_upd   = hours_r;
      endcase
    end
  end

  always_comb begin
    seg_nxt      = seg_r;
    pos_nxt      = pos_r;
    ctl_nxt      = ctl_r;
    hours_nxt    = hours_r;
    mins_nxt     = mins_r;
    secs_nxt     = secs_r;
    lat_deg_nxt  = lat_deg_r;
    lat_min_nxt  = lat_min_r;
    lon_deg_nxt  = lon_deg_r;
    lon_min_nxt  = lon_min_r;
    quality_nxt  = quality_r;
    sats_nxt     = sats_r;
    hdop_nxt     = hdop_r;
    alt_nxt      = alt_r;
    und_nxt      = und_r;
    flag_lat_nxt = flag_lat_r;
    flag_lon_nxt = flag_lon_r;
    alt_neg_nxt  = alt_neg_r;
    und_neg_nxt  = und_neg_r;
    if (last) begin
      seg_nxt      = '0;
      pos_nxt      = '0;
      ctl_nxt      = '0;
      hours_nxt    = '0;
      mins_nxt     = '0;
      secs_nxt     = '0;
      lat_deg_nxt  = '0;
      lat_min_nxt  = '0;
      lon_deg_nxt  = '0;
      lon_min_nxt  = '0;
      quality_nxt  = '0;
      sats_nxt     = '0;
      hdop_nxt     = '0;
      alt_nxt      = '0;
      und_nxt      = '0;
      flag_lat_nxt = 1'b0;
      flag_lon_nxt = 1'b0;
      alt_neg_nxt  = 1'b0;
      und_neg_nxt  = 1'b0;
    end else if (step_i) begin
      seg_nxt      = seg_upd;
      pos_nxt      = pos_upd;
      ctl_nxt      = ctl_upd;
      hours_nxt    = hours_upd;
      mins_nxt     = mins_upd;
      secs_nxt     = secs_upd;
      lat_deg_nxt  = lat_deg_upd;
      lat_min_nxt  = lat_min_upd;
      lon_deg_nxt  = lon_deg_upd;
      lon_min_nxt  = lon_min_upd;
      quality_nxt  = quality_upd;
      sats_nxt     = sats_upd;
      hdop_nxt     = hdop_upd;
      alt_nxt      = alt_upd;
      und_nxt      = und_upd;
      flag_lat_nxt = flag_lat_upd;
      flag_lon_nxt = flag_lon_upd;
      alt_neg_nxt  = alt_neg_upd;
      und_neg_nxt  = und_neg_upd;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      seg_r      <= '0;
      pos_r      <= '0;
      ctl_r      <= '0;
      hours_r    <= '0;
      mins_r     <= '0;
      secs_r     <= '0;
      lat_deg_r  <= '0;
      lat_min_r  <= '0;
      lon_deg_r  <= '0;
      lon_min_r  <= '0;
      quality_r  <= '0;
      sats_r     <= '0;
      hdop_r     <= '0;
      alt_r      <= '0;
      und_r      <= '0;
      flag_lat_r <= 1'b0;
      flag_lon_r <= 1'b0;
      alt_neg_r  <= 1'b0;
      und_neg_r  <= 1'b0;
    end else begin
      seg_r      <= seg_nxt;
      pos_r      <= pos_nxt;
      ctl_r      <= ctl_nxt;
      hours_r    <= hours_nxt;
      mins_r     <= mins_nxt;
      secs_r     <= secs_nxt;
      lat_deg_r  <= lat_deg_nxt;
      lat_min_r  <= lat_min_nxt;
      lon_deg_r  <= lon_deg_nxt;
      lon_min_r  <= lon_min_nxt;
      quality_r  <= quality_nxt;
      sats_r     <= sats_nxt;
      hdop_r     <= hdop_nxt;
      alt_r      <= alt_nxt;
      und_r      <= und_nxt;
      flag_lat_r <= flag_lat_nxt;
      flag_lon_r <= flag_lon_nxt;
      alt_neg_r  <= alt_neg_nxt;
      und_neg_r  <= und_neg_nxt;
    end
  end

  // record assembly from the state including the final byte
  always_comb begin
    rec_o = '0;
    if ({1'b0, seg_upd} + 6'd1 != SENTENCE_SEGMENTS) begin
      rec_o.status = 1'b1;
    end else begin
      rec_o.utc_time_packed  = {hours_upd, mins_upd, secs_upd};
      rec_o.lat_degrees      = lat_deg_upd;
      rec_o.lat_minutes_e7   = lat_min_upd;
      rec_o.lon_degrees      = lon_deg_upd;
      rec_o.lon_minutes_e7   = lon_min_upd;
      rec_o.hemisphere_flags = {flag_lon_upd, flag_lat_upd};
      rec_o.fix_quality      = quality_upd;
      rec_o.sats_in_use      = sats_upd;
      rec_o.hdop_e2          = hdop_upd;
      if (alt_neg_upd) begin
        rec_o.altitude_e4 = $signed(32'd0 - alt_upd);
      end else begin
        rec_o.altitude_e4 = $signed((alt_upd > MAX_POSITIVE) ? MAX_POSITIVE : alt_upd);
      end
      if (und_neg_upd) begin
        rec_o.undulation_e4 = $signed(32'd0 - und_upd);
      end else begin
        rec_o.undulation_e4 = $signed((und_upd > MAX_POSITIVE) ? MAX_POSITIVE : und_upd);
      end
    end
  end

  assign rec_valid_o = last;

endmodule

### rtl/gga_sentence_field_extractor_unit.sv
// top level of the gga sentence field extractor: input and record registers around the parser
//
// Takes one character of a comma-separated GGA sentence per beat and returns one record
// after the beat flagged as the last byte. One byte is accepted every clock cycle while no last
// byte is held back: each byte is registered, then updates the sentence state as it leaves the
// input register through a single digit step (multiply-by-ten-and-add before the point, a
// weighted add after it), and a record is written to the output register in that same cycle.
// The record register is the only point of back-pressure: a last byte waits in the input
// register only while the previous record has not yet been taken, and the bytes of the next
// sentence keep flowing in meanwhile up to that point.
module gga_sentence_field_extractor_unit (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   in_valid,
  output logic                   in_ready,
  input  gga_sfx_pkg::in_beat_t  in_beat,
  output logic                   out_valid,
  input  logic                   out_ready,
  output gga_sfx_pkg::out_beat_t out_beat
);
  import gga_sfx_pkg::*;

  logic      in_v_r;
  in_beat_t  in_beat_r;
  logic      out_v_r;
  out_beat_t out_beat_r;
  logic      advance;
  logic      rec_valid;
  out_beat_t rec;

  assign advance  = in_v_r && (!in_beat_r.last_byte || !out_v_r || out_ready);
  assign in_ready = !in_v_r || advance;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_v_r <= 1'b0;
    end else if (in_ready) begin
      in_v_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      in_beat_r <= in_beat;
    end
  end

  gga_sfx_parser u_parser (
    .clk        (clk),
    .rst_n      (rst_n),
    .step_i     (advance),
    .beat_i     (in_beat_r),
    .rec_valid_o(rec_valid),
    .rec_o      (rec)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_v_r <= 1'b0;
    end else if (rec_valid) begin
      out_v_r <= 1'b1;
    end else if (out_ready) begin
      out_v_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (rec_valid) begin
      out_beat_r <= rec;
    end
  end

  assign out_valid = out_v_r;
  assign out_beat  = out_beat_r;

endmodule

### rtl/gga_sfx_checker.sv
// port-level checks for the gga sentence field extractor, bound to the top level
`include "gga_sentence_field_extractor_unit_defines.svh"

module gga_sfx_checker (
  input logic                   clk,
  input logic                   rst_n,
  input logic                   in_valid,
  input logic                   in_ready,
  input gga_sfx_pkg::in_beat_t  in_beat,
  input logic                   out_valid,
  input logic                   out_ready,
  input gga_sfx_pkg::out_beat_t out_beat
);
  import gga_sfx_pkg::*;

  logic in_waiting;
  logic out_stalled;
  logic bad_record;
  logic good_record;
  logic bad_count_cleared;
  logic fields_in_range;

  assign in_waiting        = in_valid && !in_ready;
  assign out_stalled       = out_valid && !out_ready;
  assign bad_record        = out_valid && out_beat.status;
  assign good_record       = out_valid && !out_beat.status;
  assign bad_count_cleared = out_beat.utc_time_packed == 21'd0
                          && out_beat.lat_minutes_e7 == 30'd0
                          && out_beat.altitude_e4 == 32'sd0
                          && out_beat.hdop_e2 == 16'd0;
  assign fields_in_range   = out_beat.lat_minutes_e7 <= CAP_MINUTES[29:0]
                          && out_beat.lon_minutes_e7 <= CAP_MINUTES[29:0]
                          && out_beat.fix_quality <= 4'd9
                          && out_beat.lat_degrees <= 7'd99;

  `GGA_SFX_ASSERT_NEXT(a_in_hold, in_waiting, in_valid && $stable(in_beat), "input beat not held")
  `GGA_SFX_ASSERT_NEXT(a_out_hold, out_stalled, out_valid && $stable(out_beat), "record not held")
  `GGA_SFX_ASSERT_RST(a_reset_idle, !rst_n, !out_valid, "record beat right after reset")
  `GGA_SFX_ASSERT_NOW(a_bad_count_zero, bad_record, bad_count_cleared, "fields set on bad count")
  `GGA_SFX_ASSERT_NOW(a_ranges, good_record, fields_in_range, "record field out of range")

endmodule

bind gga_sentence_field_extractor_unit gga_sfx_checker u_gga_sfx_checker (.*);

### test/testbench.sv
// testbench for the gga sentence field extractor: byte-level stimulus and record checks
module testbench;
  timeunit 1ns;
  timeprecision 1ps;

  import gga_sfx_pkg::*;

  localparam int CLK_HALF     = 6;
  localparam int CYCLE_LIMIT  = 200000;
  localparam int MAX_PRINTED  = 60;
  localparam int DRAIN_CYCLES = 8;

  localparam int SEG_ALT_UNITS = 10;
  localparam int SEG_UND_UNITS = 12;
  localparam int SEG_AGE       = 13;
  localparam int SEG_STATION   = 14;

  logic      clk       = 1'b0;
  logic      rst_n     = 1'b0;
  logic      in_valid  = 1'b0;
  logic      in_ready;
  in_beat_t  in_beat   = '0;
  logic      out_valid;
  logic      out_ready = 1'b0;
  out_beat_t out_beat;

  int send_idle_pct   = 28;
  int stall_pct       = 28;
  int bytes_accepted  = 0;
  int records_checked = 0;
  int mismatch_count  = 0;
  int cycle_count     = 0;

  logic [7:0] sentence_q[$];
  out_beat_t  awaited_records[$];
  out_beat_t  oldest_record;

  // parser state mirrored from the block
  logic [4:0]  seg_idx;
  logic [5:0]  char_pos;
  logic        scan_stopped;
  logic        scan_after_point;
  int unsigned scan_frac_seen;
  logic [31:0] acc_val [13];
  logic        lat_flag;
  logic        lon_flag;
  logic        alt_negative;
  logic        und_negative;

  gga_sentence_field_extractor_unit u_dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_beat   (in_beat),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_beat  (out_beat)
  );

  always #CLK_HALF clk = ~clk;

  always @(posedge clk) begin
    out_ready <= ($urandom_range(0, 99) >= stall_pct);
  end

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("testbench failed");
      $finish;
    end
  end

  function automatic longint unsigned ten_to(int unsigned n);
    longint unsigned v;
    v = 1;
    repeat ((n > 9) ? 9 : n) v = v * 10;
    return v;
  endfunction

  function automatic void restart_scan();
    scan_stopped     = 1'b0;
    scan_after_point = 1'b0;
    scan_frac_seen   = 0;
  endfunction

  function automatic void clear_sentence();
    seg_idx  = '0;
    char_pos = '0;
    restart_scan();
    foreach (acc_val[i]) acc_val[i] = '0;
    lat_flag     = 1'b0;
    lon_flag     = 1'b0;
    alt_negative = 1'b0;
    und_negative = 1'b0;
  endfunction

  function automatic void scan_char(acc_sel_t slot, logic [7:0] c, int unsigned frac,
                                    logic [31:0] cap);
    longint unsigned sum;
    longint unsigned digit;
    if (scan_stopped) return;
    if (c >= CHAR_ZERO && c <= CHAR_NINE) begin
      digit = 64'(c - CHAR_ZERO);
      sum   = 64'(acc_val[slot]);
      if (!scan_after_point) begin
        sum = sum * 10 + digit * ten_to(frac);
      end else if (scan_frac_seen < frac) begin
        scan_frac_seen++;
        sum = sum + digit * ten_to(frac - scan_frac_seen);
      end
      if (sum > 64'(cap)) sum = 64'(cap);
      acc_val[slot] = sum[31:0];
    end else if (c == CHAR_POINT && frac > 0 && !scan_after_point) begin
      scan_after_point = 1'b1;
    end else begin
      scan_stopped = 1'b1;
    end
  endfunction

  function automatic void feed_char(logic [7:0] c);
    case (seg_idx)
      SEG_TIME: begin
        if (char_pos == 6'd2 || char_pos == 6'd4) restart_scan();
        if (char_pos < 6'd2) scan_char(SEL_HOURS, c, NO_FRAC_DIGITS, CAP_TWO_DIGIT);
        else if (char_pos < 6'd4) scan_char(SEL_MINUTES, c, NO_FRAC_DIGITS, CAP_TWO_DIGIT);
        else if (char_pos < 6'd6) scan_char(SEL_SECONDS, c, NO_FRAC_DIGITS, CAP_TWO_DIGIT);
      end
      SEG_LAT: begin
        if (char_pos == 6'd2) restart_scan();
        if (char_pos < 6'd2) scan_char(SEL_LAT_DEG, c, NO_FRAC_DIGITS, CAP_TWO_DIGIT);
        else scan_char(SEL_LAT_MIN, c, MINUTE_FRAC_DIGITS, CAP_MINUTES);
      end
      SEG_NS: begin
        if (char_pos == 6'd0 && c == CHAR_N) lat_flag = 1'b0;
      end
      SEG_LON: begin
        if (char_pos == 6'd3) restart_scan();
        if (char_pos < 6'd3) scan_char(SEL_LON_DEG, c, NO_FRAC_DIGITS, CAP_THREE_DIGIT);
        else scan_char(SEL_LON_MIN, c, MINUTE_FRAC_DIGITS, CAP_MINUTES);
      end
      SEG_EW: begin
        if (char_pos == 6'd0 && c == CHAR_E) lon_flag = 1'b0;
      end
      SEG_QUALITY: begin
        if (char_pos == 6'd0) scan_char(SEL_QUALITY, c, NO_FRAC_DIGITS, CAP_ONE_DIGIT);
      end
      SEG_SATS: scan_char(SEL_SATS, c, NO_FRAC_DIGITS, CAP_SATS);
      SEG_HDOP: scan_char(SEL_HDOP, c, HDOP_FRAC_DIGITS, CAP_HDOP);
      SEG_ALT: begin
        if (char_pos == 6'd0 && (c == CHAR_MINUS || c == CHAR_PLUS))
          alt_negative = alt_negative | (c == CHAR_MINUS);
        else
          scan_char(SEL_ALT, c, METRE_FRAC_DIGITS, CAP_MAGNITUDE);
      end
      SEG_UND: begin
        if (char_pos == 6'd0 && (c == CHAR_MINUS || c == CHAR_PLUS))
          und_negative = und_negative | (c == CHAR_MINUS);
        else
          scan_char(SEL_UND, c, METRE_FRAC_DIGITS, CAP_MAGNITUDE);
      end
      default: ;
    endcase
  endfunction

  function automatic logic [31:0] signed_value(logic [31:0] mag, logic neg);
    if (neg) return 32'd0 - mag;
    return (mag > MAX_POSITIVE) ? MAX_POSITIVE : mag;
  endfunction

  // returns 1 when the byte closes a sentence and a record is due
  function automatic bit parse_sentence_byte(logic [7:0] c, logic last, output out_beat_t rec);
    rec = '0;
    if (c == CHAR_COMMA) begin
      if (seg_idx != SEG_MAX) seg_idx = seg_idx + 5'd1;
      char_pos = '0;
      restart_scan();
      if (seg_idx == SEG_NS) lat_flag = 1'b1;
      if (seg_idx == SEG_EW) lon_flag = 1'b1;
    end else begin
      feed_char(c);
      if (char_pos != POS_MAX) char_pos = char_pos + 6'd1;
    end
    if (!last) return 1'b0;
    if (int'(seg_idx) + 1 != int'(SENTENCE_SEGMENTS)) begin
      rec.status = 1'b1;
    end else begin
      rec.utc_time_packed  = {acc_val[SEL_HOURS][6:0], acc_val[SEL_MINUTES][6:0],
                              acc_val[SEL_SECONDS][6:0]};
      rec.lat_degrees      = acc_val[SEL_LAT_DEG][6:0];
      rec.lat_minutes_e7   = acc_val[SEL_LAT_MIN][29:0];
      rec.lon_degrees      = acc_val[SEL_LON_DEG][9:0];
      rec.lon_minutes_e7   = acc_val[SEL_LON_MIN][29:0];
      rec.hemisphere_flags = {lon_flag, lat_flag};
      rec.fix_quality      = acc_val[SEL_QUALITY][3:0];
      rec.sats_in_use      = acc_val[SEL_SATS][7:0];
      rec.hdop_e2          = acc_val[SEL_HDOP][15:0];
      rec.altitude_e4      = signed_value(acc_val[SEL_ALT], alt_negative);
      rec.undulation_e4    = signed_value(acc_val[SEL_UND], und_negative);
    end
    clear_sentence();
    return 1'b1;
  endfunction

  task automatic report_mismatch(string what, longint unsigned got, longint unsigned want);
    mismatch_count++;
    if (mismatch_count <= MAX_PRINTED)
      $display("record %0d: %s got %0h expected %0h", records_checked, what, got, want);
  endtask

  always @(posedge clk) begin
    if (rst_n && out_valid && out_ready) begin
      records_checked++;
      if (awaited_records.size() == 0) begin
        report_mismatch("record with none awaited", 0, 0);
      end else begin
        oldest_record = awaited_records.pop_front();
        if (out_beat.status !== oldest_record.status)
          report_mismatch("status", out_beat.status, oldest_record.status);
        if (out_beat.utc_time_packed !== oldest_record.utc_time_packed)
          report_mismatch("utc time", out_beat.utc_time_packed, oldest_record.utc_time_packed);
        if (out_beat.lat_degrees !== oldest_record.lat_degrees)
          report_mismatch("lat degrees", out_beat.lat_degrees, oldest_record.lat_degrees);
        if (out_beat.lat_minutes_e7 !== oldest_record.lat_minutes_e7)
          report_mismatch("lat minutes", out_beat.lat_minutes_e7, oldest_record.lat_minutes_e7);
        if (out_beat.lon_degrees !== oldest_record.lon_degrees)
          report_mismatch("lon degrees", out_beat.lon_degrees, oldest_record.lon_degrees);
        if (out_beat.lon_minutes_e7 !== oldest_record.lon_minutes_e7)
          report_mismatch("lon minutes", out_beat.lon_minutes_e7, oldest_record.lon_minutes_e7);
        if (out_beat.hemisphere_flags !== oldest_record.hemisphere_flags)
          report_mismatch("hemisphere", out_beat.hemisphere_flags,
                          oldest_record.hemisphere_flags);
        if (out_beat.fix_quality !== oldest_record.fix_quality)
          report_mismatch("fix quality", out_beat.fix_quality, oldest_record.fix_quality);
        if (out_beat.sats_in_use !== oldest_record.sats_in_use)
          report_mismatch("satellites", out_beat.sats_in_use, oldest_record.sats_in_use);
        if (out_beat.hdop_e2 !== oldest_record.hdop_e2)
          report_mismatch("hdop", out_beat.hdop_e2, oldest_record.hdop_e2);
        if (out_beat.altitude_e4 !== oldest_record.altitude_e4)
          report_mismatch("altitude", out_beat.altitude_e4, oldest_record.altitude_e4);
        if (out_beat.undulation_e4 !== oldest_record.undulation_e4)
          report_mismatch("undulation", out_beat.undulation_e4, oldest_record.undulation_e4);
      end
    end
  end

  task automatic send_byte(input logic [7:0] c, input logic last);
    out_beat_t rec;
    while ($urandom_range(0, 99) < send_idle_pct) begin
      in_valid <= 1'b0;
      in_beat  <= 9'($urandom);
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_beat  <= '{sentence_byte: c, last_byte: last};
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    bytes_accepted++;
    if (parse_sentence_byte(c, last, rec)) awaited_records.push_back(rec);
  endtask

  task automatic send_sentence();
    for (int i = 0; i < sentence_q.size(); i++)
      send_byte(sentence_q[i], i == sentence_q.size() - 1);
    sentence_q.delete();
  endtask

  function automatic void push_text(string t);
    for (int i = 0; i < t.len(); i++) sentence_q.push_back(t[i]);
  endfunction

  task automatic send_text(string t);
    push_text(t);
    send_sentence();
  endtask

  function automatic logic [7:0] rand_digit();
    if ($urandom_range(0, 4) == 0) return CHAR_NINE;
    return CHAR_ZERO + 8'($urandom_range(0, 9));
  endfunction

  function automatic logic [7:0] junk_char();
    logic [7:0] j;
    j = 8'($urandom_range(32, 126));
    return (j == CHAR_COMMA) ? "e" : j;
  endfunction

  function automatic void append_number(int lo, int hi, int frac_hi, bit signed_ok);
    if (signed_ok && $urandom_range(0, 2) == 0)
      sentence_q.push_back($urandom_range(0, 1) ? CHAR_MINUS : CHAR_PLUS);
    repeat ($urandom_range(lo, hi)) sentence_q.push_back(rand_digit());
    if (frac_hi > 0 && $urandom_range(0, 3) != 0) begin
      sentence_q.push_back(CHAR_POINT);
      repeat ($urandom_range(0, frac_hi)) sentence_q.push_back(rand_digit());
    end
    if ($urandom_range(0, 11) == 0) begin
      sentence_q.push_back(junk_char());
      sentence_q.push_back(rand_digit());
    end
  endfunction

  function automatic void push_hemisphere(logic [7:0] wanted, logic [7:0] other);
    case ($urandom_range(0, 4))
      0, 1: sentence_q.push_back(wanted);
      2: sentence_q.push_back(other);
      3: ;
      default: begin
        sentence_q.push_back($urandom_range(0, 1) ? other : junk_char());
        sentence_q.push_back(wanted);
      end
    endcase
  endfunction

  function automatic void build_gga_sentence(bit broken);
    int last_seg;
    last_seg = SEG_STATION;
    if (broken)
      last_seg = $urandom_range(0, 1) ? $urandom_range(0, 13) : $urandom_range(15, 40);
    push_text(($urandom_range(0, 7) == 0) ? "#XYGGA" : "$GPGGA");
    for (int seg = 1; seg <= last_seg; seg++) begin
      sentence_q.push_back(CHAR_COMMA);
      case (seg)
        SEG_TIME: begin
          repeat (($urandom_range(0, 7) == 0) ? $urandom_range(0, 9) : 6)
            sentence_q.push_back(rand_digit());
          if ($urandom_range(0, 1)) begin
            sentence_q.push_back(CHAR_POINT);
            repeat (2) sentence_q.push_back(rand_digit());
          end
        end
        SEG_LAT:       append_number(0, 6, 9, 1'b0);
        SEG_NS:        push_hemisphere(CHAR_N, "S");
        SEG_LON:       append_number(0, 7, 9, 1'b0);
        SEG_EW:        push_hemisphere(CHAR_E, "W");
        SEG_QUALITY: begin
          if ($urandom_range(0, 5) != 0) sentence_q.push_back(rand_digit());
          else if ($urandom_range(0, 1)) sentence_q.push_back(junk_char());
        end
        SEG_SATS:      append_number(0, 3, 1, 1'b0);
        SEG_HDOP:      append_number(0, 3, 3, 1'b0);
        SEG_ALT:       append_number(0, 9, 6, 1'b1);
        SEG_ALT_UNITS: push_text("M");
        SEG_UND:       append_number(0, 9, 6, 1'b1);
        SEG_UND_UNITS: push_text("M");
        SEG_AGE:       append_number(0, 2, 1, 1'b0);
        SEG_STATION: begin
          push_text("*");
          repeat (2) sentence_q.push_back(rand_digit());
        end
        default:       append_number(0, 3, 2, 1'b1);
      endcase
    end
  endfunction

  function automatic void build_noise_line();
    repeat ($urandom_range(1, 40))
      sentence_q.push_back(($urandom_range(0, 3) == 0) ? CHAR_COMMA : 8'($urandom_range(0, 255)));
  endfunction

  task automatic test_reference_sentences();
    send_text("$GPGGA,123519.00,4807.038,N,01131.000,E,1,08,0.9,545.4,M,46.9,M,,*47");
    send_text("$GNGGA,000000,0000.0000000,S,00000.0000000,W,0,00,0.00,-0.0001,M,-12.3456,M,1.0,0000*5A");
  endtask

  task automatic test_saturation_limits();
    send_text("$GPGGA,995999.99,9999.99999999999,N,99999.999999999,E,9,99999,655.36,99999999.9,M,-999999.99999,M,,*7F");
    send_text("$GPGGA,235959,8959.9999999,N,17959.9999999,E,8,255,655.35,214748.3648,M,-214748.3648,M,,");
    send_text("$GPGGA,,,,,,,,,214748.3647,M,-214748.3647,M,,");
  endtask

  task automatic test_sentence_length();
    send_text("$GPGGA,1,2,3");
    push_text("$GPGGA");
    repeat (13) sentence_q.push_back(CHAR_COMMA);
    send_sentence();
    push_text("$GPGGA");
    repeat (14) sentence_q.push_back(CHAR_COMMA);
    send_sentence();
    push_text("$GPGGA");
    repeat (15) sentence_q.push_back(CHAR_COMMA);
    send_text("*00");
    push_text("$GPGGA");
    repeat (40) sentence_q.push_back(CHAR_COMMA);
    send_sentence();
    send_text("X");
    send_text(",");
  endtask

  task automatic test_short_and_empty_values();
    send_text("$GPGGA,1,4,N,0,E,,,,,M,,M,,");
    send_text("$GPGGA,12a4x6,48.5,S,011,W,.,1a,.5,-,M,+,M,,");
    send_text("$GPGGA,,,,,,,,,--5,M,-,M,,");
  endtask

  task automatic test_signs_and_scan_stops();
    send_text("$GPGGA,1234,4807.038.5,N,01131e5,E,1,1 2,1e2,+12.5e3,M,-0.00005,M,,*47");
    send_text("$GPGGA,1234.5,12,n,1234,e,12,300,1.234,-5,M,5-,M,,*00");
  endtask

  task automatic test_long_segments();
    push_text("$GPGGA,1234");
    repeat (70) sentence_q.push_back("7");
    push_text(",12");
    repeat (70) sentence_q.push_back("3");
    push_text(".5,N,123");
    repeat (66) sentence_q.push_back("4");
    push_text(",E,1,9999999,1");
    repeat (64) sentence_q.push_back("2");
    send_text(",-1.5,M,2,M,,*00");
    push_text("$GPGGA,,00.1");
    repeat (70) sentence_q.push_back("9");
    push_text(",S,,W,,,,1.");
    repeat (40) sentence_q.push_back("8");
    send_text(",M,,M,,");
  endtask

  task automatic test_odd_bytes();
    push_text("$G");
    sentence_q.push_back(8'h00);
    sentence_q.push_back(8'hFF);
    sentence_q.push_back(8'h80);
    push_text(",12");
    sentence_q.push_back(8'h7F);
    send_text("56,4807.038,NE,01131.000,EN,1,08,0.9,545.4,M,46.9,M,,*47");
    send_text("#XXGGA,010203,0000.0000001,X,00000.0000001,X,1,1,0,0,M,0,M,,*00");
  endtask

  task automatic test_random_sentences(int sender_pct, int receiver_pct);
    int start_bytes;
    send_idle_pct = sender_pct;
    stall_pct     = receiver_pct;
    start_bytes   = bytes_accepted;
    while (bytes_accepted - start_bytes < 40) begin
      case ($urandom_range(0, 9))
        0:       build_noise_line();
        1:       build_gga_sentence(1'b1);
        default: build_gga_sentence(1'b0);
      endcase
      send_sentence();
    end
  endtask

  initial begin
    clear_sentence();
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;
    test_reference_sentences();
    test_saturation_limits();
    test_sentence_length();
    test_short_and_empty_values();
    test_signs_and_scan_stops();
    test_long_segments();
    test_odd_bytes();
    test_random_sentences(0, 0);
    test_random_sentences(59, 0);
    test_random_sentences(0, 59);
    test_random_sentences(28, 28);
    in_valid <= 1'b0;
    while (awaited_records.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (mismatch_count == 0) begin
      $display("testbench passed");
    end else begin
      $display("testbench failed");
    end
    $finish;
  end

endmodule

### sim.f
+incdir+rtl
rtl/gga_sfx_pkg.sv
rtl/gga_sfx_scan.sv
rtl/gga_sfx_parser.sv
rtl/gga_sentence_field_extractor_unit.sv
rtl/gga_sfx_checker.sv
test/testbench.sv
